### src/skc_pkg.sv
// Shared types, constants and the control program of the soft-knee gain computer.
package skc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned COEF_FRAC     = 16;
  localparam int unsigned SLOPE_FRAC    = 14;

  // shared multiplier: 28-bit by 17-bit unsigned
  localparam int unsigned MUL_A_W = 28;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [14:0] RED_MAX    = 15'h7fff;
  localparam logic [16:0] COEF_ONE   = 17'h10000;
  localparam logic [32:0] ROUND_HALF = 33'h0_0000_8000;

  // register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HALF_KNEE = 3'd1;
  localparam logic [2:0] REG_KNEE_COEF = 3'd2;
  localparam logic [2:0] REG_SLOPE     = 3'd3;
  localparam logic [2:0] REG_ATTACK    = 3'd4;
  localparam logic [2:0] REG_RELEASE   = 3'd5;
  localparam logic [2:0] REG_MAKEUP    = 3'd6;

  // register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'hec00;  // -20 dB
  localparam logic [12:0] HALF_KNEE_RST = 13'd1280;
  localparam logic [15:0] KNEE_COEF_RST = 16'd3277;
  localparam logic [14:0] SLOPE_RST     = 15'h6000;  // -0.5
  localparam logic [15:0] ATTACK_RST    = 16'd60000;
  localparam logic [15:0] RELEASE_RST   = 16'd64000;
  localparam logic [15:0] MAKEUP_RST    = 16'd1280;

  typedef enum logic [2:0] {
    ST_DD,
    ST_KNEE,
    ST_SLOPE,
    ST_TGT,
    ST_ALPHA,
    ST_BETA,
    ST_SMOOTH,
    ST_EMIT
  } step_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DD,
    MUL_KNEE,
    MUL_SLOPE,
    MUL_ALPHA,
    MUL_BETA
  } mul_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_HARD,
    JMP_REL
  } jmp_e;

  typedef struct packed {
    mul_e  mul;
    logic  ld_tgt;
    logic  ld_acc;
    logic  ld_st;
    logic  emit;
    jmp_e  jmp;
    step_e dest;
  } cw_t;

  typedef struct packed {
    logic signed [15:0] threshold;
    logic        [12:0] half_knee;
    logic        [15:0] knee_coef;
    logic signed [14:0] slope;
    logic        [15:0] atk_coef;
    logic        [15:0] rel_coef;
    logic signed [15:0] makeup;
  } cfg_t;

  typedef struct packed {
    logic hard;
    logic rel;
  } flags_t;

  localparam cw_t CW_NOP = '{
    mul:    MUL_NONE,
    ld_tgt: 1'b0,
    ld_acc: 1'b0,
    ld_st:  1'b0,
    emit:   1'b0,
    jmp:    JMP_NONE,
    dest:   ST_DD
  };

  // control store, one word per step
  function automatic cw_t ucode(step_e s);
    cw_t c;
    c = CW_NOP;
    case (s)
      ST_DD: begin
        c.mul  = MUL_DD;
        c.jmp  = JMP_HARD;
        c.dest = ST_SLOPE;
      end
      ST_KNEE:   c.mul = MUL_KNEE;
      ST_SLOPE:  c.mul = MUL_SLOPE;
      ST_TGT:    c.ld_tgt = 1'b1;
      ST_ALPHA: begin
        c.mul  = MUL_ALPHA;
        c.jmp  = JMP_REL;
        c.dest = ST_SMOOTH;
      end
      ST_BETA: begin
        c.mul    = MUL_BETA;
        c.ld_acc = 1'b1;
      end
      ST_SMOOTH: c.ld_st = 1'b1;
      ST_EMIT:   c.emit = 1'b1;
      default:   c = CW_NOP;
    endcase
    return c;
  endfunction

endpackage

### src/skc_datapath.sv
// Datapath of the gain computer: overshoot, shared multiplier, knee, smoother, gain.
module skc_datapath import skc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic signed [15:0] level_db_i,
  input  logic               frame_start_i,
  input  cfg_t               cfg_i,
  input  cw_t                cw_i,
  output flags_t             flags_o,
  output logic        [14:0] red_o,
  output logic signed [15:0] gain_o
);

  localparam int unsigned KNEE_SH = FRAC_BITS + COEF_FRAC;

  logic signed [16:0] over;
  logic signed [16:0] wext;
  logic signed [16:0] dsum;
  logic               knee_hit;

  logic               hard_q;
  logic        [13:0] d_q;
  logic        [15:0] hrect_q;
  logic [PROD_W-1:0]  prod_q;
  logic        [30:0] acc_q;
  logic        [14:0] tgt_q;
  logic               atk_q;
  logic        [14:0] st_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic        [43:0] knee_sh;
  logic [MUL_A_W-1:0] rect;
  logic        [14:0] slope_u;
  logic        [14:0] neg_slope;
  logic        [16:0] beta;
  logic        [14:0] tgt_next;
  logic        [32:0] sum;
  logic        [14:0] st_att;
  logic        [14:0] st_new;
  logic signed [16:0] diff;

  // overshoot and knee region, evaluated on the accepted word
  always_comb begin
    over     = {level_db_i[15], level_db_i} - {cfg_i.threshold[15], cfg_i.threshold};
    wext     = signed'({4'b0000, cfg_i.half_knee});
    dsum     = over + wext;
    knee_hit = (cfg_i.half_knee != '0) && (over > -wext) && (over < wext);
  end

  always_comb begin
    knee_sh   = prod_q[43:0] >> KNEE_SH;
    rect      = hard_q ? {12'b0, hrect_q} : knee_sh[MUL_A_W-1:0];
    slope_u   = cfg_i.slope;
    // positive slope counts as zero slope
    neg_slope = slope_u[14] ? (~slope_u + 15'd1) : '0;
    beta      = COEF_ONE - {1'b0, cfg_i.atk_coef};
  end

  always_comb begin
    case (cw_i.mul)
      MUL_DD: begin
        mul_a = {14'b0, d_q};
        mul_b = {3'b0, d_q};
      end
      MUL_KNEE: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = {1'b0, cfg_i.knee_coef};
      end
      MUL_SLOPE: begin
        mul_a = rect;
        mul_b = {2'b0, neg_slope};
      end
      MUL_ALPHA: begin
        mul_a = {13'b0, st_q};
        mul_b = {1'b0, atk_q ? cfg_i.atk_coef : cfg_i.rel_coef};
      end
      MUL_BETA: begin
        mul_a = {13'b0, tgt_q};
        mul_b = beta;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    tgt_next = (|prod_q[PROD_W-1:29]) ? RED_MAX : prod_q[28:14];
    sum      = {2'b00, acc_q} + prod_q[32:0] + ROUND_HALF;
    st_att   = (|sum[32:31]) ? RED_MAX : sum[30:16];
    st_new   = atk_q ? st_att : prod_q[30:16];
    diff     = {cfg_i.makeup[15], cfg_i.makeup} - {2'b00, st_q};
    gain_o   = (diff[16] && !diff[15]) ? 16'sh8000 : diff[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hard_q  <= !knee_hit;
      d_q     <= dsum[13:0];
      hrect_q <= over[16] ? 16'h0000 : over[15:0];
    end
    if (cw_i.mul != MUL_NONE) begin
      prod_q <= mul_p;
    end
    if (cw_i.ld_acc) begin
      acc_q <= prod_q[30:0];
    end
    if (cw_i.ld_tgt) begin
      tgt_q <= tgt_next;
      atk_q <= tgt_next > st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (load_i && frame_start_i) begin
      st_q <= '0;
    end else if (cw_i.ld_st) begin
      st_q <= st_new;
    end
  end

  assign flags_o.hard = hard_q;
  assign flags_o.rel  = !atk_q;
  assign red_o        = st_q;

endmodule

### src/soft_knee_compressor_gain.sv
// Soft-knee compressor gain computer: sequencer, configuration and output register.
//
// One input word per spectral bin: level_db_i (Q8.8 dB) and frame_start_i, which
// clears the smoother before that bin. One output word per input: gain_db_o, the
// makeup gain minus the smoothed reduction (saturated), and reduction_db_o.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// A short microprogram steps one shared 28x17 multiplier through the knee square,
// the knee scale, the slope and the attack/release blend. An accepted word takes
// 6 steps (hard knee or outside the knee, release) up to 8 steps (inside the
// knee, attack); in_stall_o is high for those steps, so no new word is taken
// meanwhile. The result lands in the output register on the last step and
// is valid from the next cycle. While the receiver stalls, the finished word
// holds and the next input is still taken; its last step waits until the output
// register is free. Reset clears the smoother, empties the output register and
// loads the register defaults. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) take effect at once; indexes outside the map are ignored.
module soft_knee_compressor_gain import skc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] level_db_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] gain_db_o,
  output logic        [14:0] reduction_db_o,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [15:0] cfg_data_i
);

  cfg_t   cfg_q;
  logic   busy_q, busy_d;
  step_e  pc_q, pc_d;
  cw_t    cw;
  flags_t flags;
  logic   in_accept;
  logic   out_free;
  logic   emit_fire;
  logic   take_jump;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] gain_q;
  logic        [14:0] red_q;
  logic signed [15:0] dp_gain;
  logic        [14:0] dp_red;

  assign in_accept = in_valid_i && !busy_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.half_knee <= HALF_KNEE_RST;
      cfg_q.knee_coef <= KNEE_COEF_RST;
      cfg_q.slope     <= SLOPE_RST;
      cfg_q.atk_coef  <= ATTACK_RST;
      cfg_q.rel_coef  <= RELEASE_RST;
      cfg_q.makeup    <= MAKEUP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: cfg_q.threshold <= cfg_data_i;
        REG_HALF_KNEE: cfg_q.half_knee <= cfg_data_i[12:0];
        REG_KNEE_COEF: cfg_q.knee_coef <= cfg_data_i;
        REG_SLOPE:     cfg_q.slope     <= cfg_data_i[14:0];
        REG_ATTACK:    cfg_q.atk_coef  <= cfg_data_i;
        REG_RELEASE:   cfg_q.rel_coef  <= cfg_data_i;
        REG_MAKEUP:    cfg_q.makeup    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control outputs of the current step
  always_comb begin
    cw        = busy_q ? ucode(pc_q) : CW_NOP;
    emit_fire = cw.emit && out_free;
    case (cw.jmp)
      JMP_HARD: take_jump = flags.hard;
      JMP_REL:  take_jump = flags.rel;
      default:  take_jump = 1'b0;
    endcase
  end

  // sequencer next state
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (in_accept) begin
        busy_d = 1'b1;
        pc_d   = ST_DD;
      end
    end else if (cw.emit) begin
      if (out_free) begin
        busy_d = 1'b0;
      end
    end else if (take_jump) begin
      pc_d = cw.dest;
    end else begin
      pc_d = step_e'(pc_q + 3'd1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= ST_DD;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      gain_q <= dp_gain;
      red_q  <= dp_red;
    end
  end

  skc_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .level_db_i   (level_db_i),
    .frame_start_i(frame_start_i),
    .cfg_i        (cfg_q),
    .cw_i         (cw),
    .flags_o      (flags),
    .red_o        (dp_red),
    .gain_o       (dp_gain)
  );

  assign in_stall_o     = busy_q;
  assign out_valid_o    = out_valid_q;
  assign gain_db_o      = gain_q;
  assign reduction_db_o = red_q;

endmodule

### src/skc_checker.sv
// Port-level checks of the gain computer, bound to the top level.
module skc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] gain_db_o,
  input logic        [14:0] reduction_db_o
);

  // shortest program is six steps
  a_min_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=>
      in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o
        ##1 in_stall_o)
    else $error("input taken again before the shortest program finished");

  // a finished word always lands in the output register
  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("sequencer went idle without an output word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(gain_db_o) && $stable(reduction_db_o)))
    else $error("stalled output word changed");

endmodule

bind soft_knee_compressor_gain skc_checker u_skc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .gain_db_o     (gain_db_o),
  .reduction_db_o(reduction_db_o)
);

### bench/soft_knee_compressor_gain_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the soft-knee compressor gain computer.
module soft_knee_compressor_gain_test import skc_pkg::*;;

  localparam int          NUM_PHASES     = 10;
  localparam int          BINS_PER_PHASE = 43;
  localparam int          CYCLE_LIMIT    = 200000;
  localparam logic [2:0]  REG_UNMAPPED   = 3'd7;

  typedef struct {
    logic signed [15:0] gain;
    logic [14:0]        red;
  } gain_word_t;

  // tracks register file and smoother, predicts one gain word per bin
  class gain_tracker;
    logic signed [15:0] thr_db;
    logic [12:0]        knee_w;
    logic [15:0]        knee_k;
    logic signed [14:0] slope_q;
    logic [15:0]        atk_a;
    logic [15:0]        rel_a;
    logic signed [15:0] makeup_db;
    logic [15:0]        smooth_red;
    gain_word_t         pending_gains[$];
    int                 errors;
    int                 compared;
    int                 frame_starts;

    function new();
      thr_db     = THRESHOLD_RST;
      knee_w     = HALF_KNEE_RST;
      knee_k     = KNEE_COEF_RST;
      slope_q    = SLOPE_RST;
      atk_a      = ATTACK_RST;
      rel_a      = RELEASE_RST;
      makeup_db  = MAKEUP_RST;
      smooth_red = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_THRESHOLD: thr_db    = data;
        REG_HALF_KNEE: knee_w    = data[12:0];
        REG_KNEE_COEF: knee_k    = data;
        REG_SLOPE:     slope_q   = data[14:0];
        REG_ATTACK:    atk_a     = data;
        REG_RELEASE:   rel_a     = data;
        REG_MAKEUP:    makeup_db = data;
        default: ;
      endcase
    endfunction

    function void take_bin(logic signed [15:0] level, logic fs);
      longint over, w, d, rect, nslope, tgt, st, gain;
      gain_word_t word;
      if (fs) begin
        smooth_red = '0;
        frame_starts++;
      end
      over = longint'(level) - longint'(thr_db);
      w    = longint'(knee_w);
      if (w > 0 && over > -w && over < w) begin
        d    = over + w;
        rect = (longint'(knee_k) * d * d) >> (FRAC_BITS_DEF + COEF_FRAC);
      end else begin
        rect = (over > 0) ? over : 0;
      end
      nslope = -longint'(slope_q);
      if (nslope < 0) nslope = 0;   // positive slope gives no reduction
      tgt = (rect * nslope) >> SLOPE_FRAC;
      if (tgt > 32767) tgt = 32767;
      st = longint'(smooth_red);
      if (tgt > st)
        st = (longint'(atk_a) * st + (65536 - longint'(atk_a)) * tgt + 32768) >> 16;
      else
        st = (longint'(rel_a) * st) >> 16;
      if (st > 32767) st = 32767;
      smooth_red = st[15:0];
      gain = longint'(makeup_db) - st;
      if (gain < -32768) gain = -32768;
      if (gain > 32767) gain = 32767;
      word.gain = gain[15:0];
      word.red  = st[14:0];
      pending_gains.push_back(word);
    endfunction

    function void match_output(logic signed [15:0] gain, logic [14:0] red);
      gain_word_t want;
      if (pending_gains.size() == 0) begin
        $error("gain_db word with no bin pending: gain_db %0d reduction_db %0d", gain, red);
        errors++;
        return;
      end
      want = pending_gains.pop_front();
      compared++;
      if (gain !== want.gain) begin
        $error("gain_db: expected %0d, got %0d", want.gain, gain);
        errors++;
      end
      if (red !== want.red) begin
        $error("reduction_db: expected %0d, got %0d", want.red, red);
        errors++;
      end
    endfunction

    function int pending();
      return pending_gains.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] level_db_i;
  logic               frame_start_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] gain_db_o;
  logic [14:0]        reduction_db_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;

  gain_tracker board;
  int          idle_pct = 10;
  int          cycle_count = 0;

  soft_knee_compressor_gain uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .level_db_i     (level_db_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gain_db_o      (gain_db_o),
    .reduction_db_o (reduction_db_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("soft_knee_compressor_gain: mismatch");
      $finish;
    end
  end

  // output side: check accepted words, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.match_output(gain_db_o, reduction_db_o);
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic push_bin(input logic [15:0] level, input logic fs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    level_db_i    <= level;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_bin(level, fs);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // junk in bits above a register's width must be dropped by the block
  function automatic logic [15:0] pad_bits(input int width, input logic [15:0] val);
    logic [15:0] junk;
    junk = 16'($urandom);
    return (junk & ~((16'd1 << width) - 16'd1)) | val;
  endfunction

  task automatic apply_profile(input int p);
    case (p)
      0: ;  // reset values
      1: begin  // hard knee, steepest slope, instant smoother
        write_cfg(REG_THRESHOLD, 16'h0000);
        write_cfg(REG_HALF_KNEE, 16'he000);
        write_cfg(REG_KNEE_COEF, 16'hffff);
        write_cfg(REG_SLOPE,     16'hc000);
        write_cfg(REG_ATTACK,    16'd0);
        write_cfg(REG_RELEASE,   16'd0);
        write_cfg(REG_MAKEUP,    16'h7fff);
      end
      2: begin  // widest legal knee, slowest smoother, gain floor
        write_cfg(REG_THRESHOLD, 16'h8000);
        write_cfg(REG_HALF_KNEE, 16'd5120);
        write_cfg(REG_KNEE_COEF, 16'd32768);
        write_cfg(REG_SLOPE,     16'h4000);
        write_cfg(REG_ATTACK,    16'hffff);
        write_cfg(REG_RELEASE,   16'hffff);
        write_cfg(REG_MAKEUP,    16'h8000);
      end
      3: begin  // out-of-range knee, positive slope, unmapped write
        write_cfg(REG_THRESHOLD, 16'h7fff);
        write_cfg(REG_HALF_KNEE, 16'h1fff);
        write_cfg(REG_KNEE_COEF, 16'hffff);
        write_cfg(REG_SLOPE,     16'h3fff);
        write_cfg(REG_ATTACK,    16'd30000);
        write_cfg(REG_RELEASE,   16'd40000);
        write_cfg(REG_MAKEUP,    16'h0000);
        write_cfg(REG_UNMAPPED,  16'h5a5a);
      end
      default: begin
        write_cfg(REG_THRESHOLD, 16'($urandom_range(65535)));
        write_cfg(REG_HALF_KNEE, pad_bits(13, ($urandom_range(3) == 0) ? 16'd0
                                              : 16'($urandom_range(5120))));
        write_cfg(REG_KNEE_COEF, 16'($urandom_range(32768)));
        write_cfg(REG_SLOPE, pad_bits(15, (p == 5) ? 16'd0
                                          : 16'(-$urandom_range(16384)) & 16'h7fff));
        write_cfg(REG_ATTACK,    16'($urandom_range(65535)));
        write_cfg(REG_RELEASE,   16'($urandom_range(65535)));
        write_cfg(REG_MAKEUP,    16'($urandom_range(65535)));
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // levels cluster around the threshold so the knee edges get hit
  function automatic logic [15:0] pick_level();
    int          w;
    int          r;
    int          off;
    logic [15:0] lvl;
    w = int'(board.knee_w);
    case ($urandom_range(9))
      0: lvl = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      1, 2, 3, 4: begin
        r   = $urandom_range(2 * w + 128);
        off = r - (w + 64);
        lvl = 16'(int'(board.thr_db) + off);
      end
      5: begin
        r   = $urandom_range(2);
        off = ($urandom_range(1) ? w : -w) + r - 1;
        lvl = 16'(int'(board.thr_db) + off);
      end
      default: lvl = 16'($urandom);
    endcase
    return lvl;
  endfunction

  task automatic run_knee_edges();
    logic signed [15:0] t;
    logic signed [15:0] w;
    t = board.thr_db;
    w = 16'(board.knee_w);
    push_bin(16'h8000, 1'b1);
    push_bin(16'h7fff, 1'b0);
    push_bin(16'h7fff, 1'b0);   // attack toward a large target
    push_bin(t, 1'b0);
    push_bin(t - w, 1'b0);
    push_bin(t - w - 16'sd1, 1'b0);
    push_bin(t - w + 16'sd1, 1'b0);
    push_bin(t + w - 16'sd1, 1'b0);
    push_bin(t + w, 1'b0);
    push_bin(t + w + 16'sd1, 1'b0);
    push_bin(16'h0000, 1'b0);
    push_bin(16'h7fff, 1'b1);   // frame start right before a loud bin
    push_bin(16'h8000, 1'b0);   // release decay
    push_bin(16'h8000, 1'b0);
    push_bin(16'h8000, 1'b0);
    push_bin(16'hb1e0, 1'b1);
    push_bin(16'hffff, 1'b0);
    push_bin(16'h5555, 1'b0);
    push_bin(16'haaaa, 1'b0);
  endtask

  initial begin
    board         = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    level_db_i    = '0;
    frame_start_i = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) wait_drained();
      idle_pct = (p == 4) ? 0 : 10;
      apply_profile(p);
      if (p <= 3) run_knee_edges();
      for (int i = 0; i < BINS_PER_PHASE; i++)
        push_bin(pick_level(), $urandom_range(9) == 0);
    end
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d gain words over %0d register settings, %0d frame starts;",
             board.compared, NUM_PHASES, board.frame_starts);
    $display("covered hard and soft knee, attack and release, saturation, idle gaps.");
    if (board.errors == 0 && board.pending() == 0)
      $display("soft_knee_compressor_gain: match");
    else
      $display("soft_knee_compressor_gain: mismatch");
    $finish;
  end

endmodule

### files.f
src/skc_pkg.sv
src/skc_datapath.sv
src/soft_knee_compressor_gain.sv
src/skc_checker.sv
bench/soft_knee_compressor_gain_test.sv
